>>> rtl/axis_endpoint_calibration_assert.svh
// Assertion macros shared by the calibration RTL.
`ifndef AXIS_ENDPOINT_CALIBRATION_ASSERT_SVH
`define AXIS_ENDPOINT_CALIBRATION_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define AXCAL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("axcal assertion failed");

// Next-cycle implication, disabled while reset is low.
`define AXCAL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("axcal assertion failed");

`endif

>>> rtl/axcal_pkg.sv
// Types, constants and divider step function for the axis calibration pipeline.
`default_nettype none

package axcal_pkg;

    localparam int unsigned WORD_W         = 16;
    localparam int unsigned CFG_IDX_W      = 3;
    localparam int unsigned DIV_STAGES     = 4;
    localparam int unsigned BITS_PER_STAGE = WORD_W / DIV_STAGES;

    localparam logic [15:0] FULL_SCALE_U = 16'd65535;
    localparam logic [15:0] NEG_SPAN     = 16'd32768;
    localparam logic [15:0] POS_SPAN     = 16'd32767;

    localparam logic [15:0] RST_MINIMUM = 16'd0;
    localparam logic [15:0] RST_CENTER  = 16'd32768;
    localparam logic [15:0] RST_MAXIMUM = 16'd65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AXIS_BIPOLAR       = 3'd0,
        CFG_RANGE_MINIMUM      = 3'd1,
        CFG_RANGE_CENTER       = 3'd2,
        CFG_RANGE_MAXIMUM      = 3'd3,
        CFG_DIRECTION_INVERTED = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        KS_FULL = 2'd0,
        KS_NEG  = 2'd1,
        KS_POS  = 2'd2
    } t_kscale;

    typedef struct packed {
        logic invalid;
        logic bipolar;
        logic neg;
        logic inv;
    } t_ctl;

    typedef struct packed {
        logic [15:0] diff;
        logic [15:0] dvs;
        t_kscale     ksel;
        t_ctl        ctl;
    } t_s1;

    // Restoring divider state: sh shifts dividend bits out and quotient bits in.
    typedef struct packed {
        logic [15:0] rem;
        logic [15:0] sh;
        logic [15:0] dvs;
        t_ctl        ctl;
    } t_div;

    function automatic logic [15:0] kscale_value(t_kscale k);
        logic [15:0] v;
        case (k)
            KS_FULL: v = FULL_SCALE_U;
            KS_NEG:  v = NEG_SPAN;
            KS_POS:  v = POS_SPAN;
            default: v = FULL_SCALE_U;
        endcase
        return v;
    endfunction

    function automatic t_div div_step(t_div a);
        logic [16:0] t;
        t_div        r;
        r = a;
        t = {a.rem, a.sh[15]};
        if (t >= {1'b0, a.dvs}) begin
            r.rem = 16'(t - {1'b0, a.dvs});
            r.sh  = {a.sh[14:0], 1'b1};
        end else begin
            r.rem = t[15:0];
            r.sh  = {a.sh[14:0], 1'b0};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/axis_endpoint_calibration.sv
// Axis calibration: one raw sample in, one item out; a new sample is taken every
// cycle unless stalled. Stage one clamps the sample and picks the span and
// divisor, stage two multiplies by the scale constant, four stages run the
// 16-bit restoring division at four quotient bits each, and the last stage
// applies inversion, sign and the invalid-endpoint flag. A stall at the output
// fills empty stages first; the input stalls only once all seven stages hold an
// item. Configuration uses a plain write port (index 0..4, indices above are
// ignored); the user must write it only while no item is in flight (not checked).
`default_nettype none

module axis_endpoint_calibration (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [15:0] i_raw_sample,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_calibrated_word,
    output logic             o_endpoints_invalid
);

    `include "axis_endpoint_calibration_assert.svh"

    localparam int unsigned NDIV = axcal_pkg::DIV_STAGES;

    // configuration registers
    logic        r_bipolar;
    logic [15:0] r_minimum;
    logic [15:0] r_center;
    logic [15:0] r_maximum;
    logic        r_inverted;

    // pipeline
    logic              r_s1_vld;
    axcal_pkg::t_s1    r_s1;
    axcal_pkg::t_s1    n_s1;
    logic              r_dv_vld [0:NDIV];
    axcal_pkg::t_div   r_dv     [0:NDIV];
    axcal_pkg::t_div   n_dv     [0:NDIV];
    logic              r_out_vld;
    logic [15:0]       r_word;
    logic              r_flag;
    logic [15:0]       n_word;

    logic              rdy_s1;
    logic              rdy_dv   [0:NDIV];
    logic              rdy_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bipolar  <= 1'b0;
            r_minimum  <= axcal_pkg::RST_MINIMUM;
            r_center   <= axcal_pkg::RST_CENTER;
            r_maximum  <= axcal_pkg::RST_MAXIMUM;
            r_inverted <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (axcal_pkg::t_cfg_reg'(i_cfg_index))
                axcal_pkg::CFG_AXIS_BIPOLAR:       r_bipolar  <= i_cfg_data[0];
                axcal_pkg::CFG_RANGE_MINIMUM:      r_minimum  <= i_cfg_data;
                axcal_pkg::CFG_RANGE_CENTER:       r_center   <= i_cfg_data;
                axcal_pkg::CFG_RANGE_MAXIMUM:      r_maximum  <= i_cfg_data;
                axcal_pkg::CFG_DIRECTION_INVERTED: r_inverted <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ready chain: a stage loads when it is empty or its successor moves
    always_comb begin
        rdy_out = !r_out_vld || !i_stall;
        rdy_dv[NDIV] = !r_dv_vld[NDIV] || rdy_out;
        for (int k = NDIV - 1; k >= 0; k--) begin
            rdy_dv[k] = !r_dv_vld[k] || rdy_dv[k+1];
        end
        rdy_s1 = !r_s1_vld || rdy_dv[0];
    end

    assign o_stall = !rdy_s1;

    // stage one: clamp, endpoint check, numerator difference and divisor
    always_comb begin
        logic [15:0] c;
        logic        bad;
        if (i_raw_sample < r_minimum) begin
            c = r_minimum;
        end else if (i_raw_sample > r_maximum) begin
            c = r_maximum;
        end else begin
            c = i_raw_sample;
        end
        bad = r_bipolar ? ((r_minimum >= r_center) || (r_center >= r_maximum))
                        : (r_minimum >= r_maximum);
        n_s1.ctl.invalid = bad;
        n_s1.ctl.bipolar = r_bipolar;
        n_s1.ctl.inv     = r_inverted;
        n_s1.ctl.neg     = 1'b0;
        if (!r_bipolar) begin
            n_s1.diff = c - r_minimum;
            n_s1.dvs  = r_maximum - r_minimum;
            n_s1.ksel = axcal_pkg::KS_FULL;
        end else if (c < r_center) begin
            n_s1.ctl.neg = 1'b1;
            n_s1.diff    = r_center - c;
            n_s1.dvs     = r_center - r_minimum;
            n_s1.ksel    = axcal_pkg::KS_NEG;
        end else begin
            n_s1.diff = c - r_center;
            n_s1.dvs  = r_maximum - r_center;
            n_s1.ksel = axcal_pkg::KS_POS;
        end
        // keep the divider well defined when the endpoints are unusable
        if (bad) begin
            n_s1.diff = '0;
            n_s1.dvs  = 16'd1;
        end
    end

    // stage two: scale multiply; quotient fits 16 bits since diff <= divisor
    always_comb begin
        logic [31:0] prod;
        prod = 32'(r_s1.diff) * 32'(axcal_pkg::kscale_value(r_s1.ksel));
        n_dv[0].rem = prod[31:16];
        n_dv[0].sh  = prod[15:0];
        n_dv[0].dvs = r_s1.dvs;
        n_dv[0].ctl = r_s1.ctl;
    end

    // division stages
    for (genvar k = 1; k <= NDIV; k++) begin : g_div
        always_comb begin
            axcal_pkg::t_div a;
            a = r_dv[k-1];
            for (int b = 0; b < axcal_pkg::BITS_PER_STAGE; b++) begin
                a = axcal_pkg::div_step(a);
            end
            n_dv[k] = a;
        end
    end

    // final stage: inversion and sign
    always_comb begin
        logic [15:0]     q;
        logic            neg;
        axcal_pkg::t_ctl ctl;
        q   = r_dv[NDIV].sh;
        ctl = r_dv[NDIV].ctl;
        neg = ctl.neg ^ ctl.inv;
        if (ctl.invalid) begin
            n_word = '0;
        end else if (!ctl.bipolar) begin
            n_word = ctl.inv ? (axcal_pkg::FULL_SCALE_U - q) : q;
        end else begin
            // inverted full negative span saturates to the positive limit
            if (ctl.inv && !neg && (q == axcal_pkg::NEG_SPAN)) begin
                q = axcal_pkg::POS_SPAN;
            end
            n_word = neg ? (~q + 16'd1) : q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            for (int k = 0; k <= NDIV; k++) begin
                r_dv_vld[k] <= 1'b0;
            end
        end else begin
            if (rdy_s1) begin
                r_s1_vld <= i_valid;
            end
            if (rdy_dv[0]) begin
                r_dv_vld[0] <= r_s1_vld;
            end
            for (int k = 1; k <= NDIV; k++) begin
                if (rdy_dv[k]) begin
                    r_dv_vld[k] <= r_dv_vld[k-1];
                end
            end
            if (rdy_out) begin
                r_out_vld <= r_dv_vld[NDIV];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_s1) begin
            r_s1 <= n_s1;
        end
        for (int k = 0; k <= NDIV; k++) begin
            if (rdy_dv[k]) begin
                r_dv[k] <= n_dv[k];
            end
        end
        if (rdy_out) begin
            r_word <= n_word;
            r_flag <= r_dv[NDIV].ctl.invalid;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_calibrated_word   = r_word;
    assign o_endpoints_invalid = r_flag;

    // the input stalls only when every stage holds an item
    `AXCAL_ASSERT_IMP(a_stall_full, i_clk, i_rst_n, o_stall, r_s1_vld && r_dv_vld[0] && r_dv_vld[1] && r_dv_vld[2] && r_dv_vld[3] && r_dv_vld[4] && r_out_vld)
    `AXCAL_ASSERT_NXT(a_accept_s1, i_clk, i_rst_n, i_valid && !o_stall, r_s1_vld)
    `AXCAL_ASSERT_IMP(a_flag_zero, i_clk, i_rst_n, o_valid && o_endpoints_invalid, o_calibrated_word == 16'd0)

    for (genvar k = 0; k <= NDIV; k++) begin : g_chk
        `AXCAL_ASSERT_IMP(a_rem_lt_dvs, i_clk, i_rst_n, r_dv_vld[k], r_dv[k].rem < r_dv[k].dvs)
    end

endmodule

`default_nettype wire
